// ===== hdl/ssvb_pkg.sv =====
// shared types and constants for the swept state-variable band-pass block
// used by the controller, the datapath and the top level
package ssvb_pkg;

    localparam int SAMPLE_WIDTH_DEF     = 24;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    localparam int FS_W    = 18;
    localparam int FREQ_W  = 31;
    localparam int STEP_W  = 25;
    localparam int DAMP_W  = 16;
    localparam int STATE_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // dividend is fc shifted up by 15, one quotient bit per step
    localparam int DIV_STEPS = FREQ_W + 15;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [FS_W-1:0]   FS_RST   = FS_W'(48000);
    localparam logic [FREQ_W-1:0] LOW_RST  = FREQ_W'(32768000);
    localparam logic [FREQ_W-1:0] HIGH_RST = FREQ_W'(196608000);
    localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(3277);
    localparam logic [DAMP_W-1:0] DAMP_RST = DAMP_W'(819);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_RATE = 3'd0,
        REG_SWEEP_LOW   = 3'd1,
        REG_SWEEP_HIGH  = 3'd2,
        REG_SWEEP_STEP  = 3'd3,
        REG_DAMPING     = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        MUL_INTERP,
        MUL_DAMP,
        MUL_BP,
        MUL_LP
    } t_mul_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_ROM,
        S_INTERP,
        S_COEF,
        S_HP,
        S_BPM,
        S_BP,
        S_LPM,
        S_LP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic     start;
        logic     div_step;
        logic     rom_rd;
        t_mul_sel mul_sel;
        logic     ld_coef;
        logic     ld_hp;
        logic     ld_band;
        logic     ld_low;
        logic     ld_out;
    } t_cmd;

endpackage

// ===== hdl/ssvb_ctrl.sv =====
// sequencer for one sample: division, table read, multiply steps, output beat
// depends on ssvb_pkg
module ssvb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ssvb_pkg::t_cmd    o_cmd
);

    ssvb_pkg::t_state                  r_state, n_state;
    logic [ssvb_pkg::DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic                              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssvb_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.mul_sel = ssvb_pkg::MUL_INTERP;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ssvb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = ssvb_pkg::S_DIV;
                end
            end
            ssvb_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == ssvb_pkg::DIV_CNT_W'(ssvb_pkg::DIV_STEPS - 1)) begin
                    n_state = ssvb_pkg::S_ROM;
                end
            end
            ssvb_pkg::S_ROM: begin
                o_cmd.rom_rd = 1'b1;
                n_state      = ssvb_pkg::S_INTERP;
            end
            ssvb_pkg::S_INTERP: begin
                o_cmd.mul_sel = ssvb_pkg::MUL_INTERP;
                n_state       = ssvb_pkg::S_COEF;
            end
            ssvb_pkg::S_COEF: begin
                o_cmd.ld_coef = 1'b1;
                o_cmd.mul_sel = ssvb_pkg::MUL_DAMP;
                n_state       = ssvb_pkg::S_HP;
            end
            ssvb_pkg::S_HP: begin
                o_cmd.ld_hp = 1'b1;
                n_state     = ssvb_pkg::S_BPM;
            end
            ssvb_pkg::S_BPM: begin
                o_cmd.mul_sel = ssvb_pkg::MUL_BP;
                n_state       = ssvb_pkg::S_BP;
            end
            ssvb_pkg::S_BP: begin
                o_cmd.ld_band = 1'b1;
                n_state       = ssvb_pkg::S_LPM;
            end
            ssvb_pkg::S_LPM: begin
                o_cmd.mul_sel = ssvb_pkg::MUL_LP;
                n_state       = ssvb_pkg::S_LP;
            end
            ssvb_pkg::S_LP: begin
                o_cmd.ld_low = 1'b1;
                n_state      = ssvb_pkg::S_OUT;
            end
            ssvb_pkg::S_OUT: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.ld_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ssvb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ssvb_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ssvb_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/ssvb_datapath.sv =====
// config registers, phase divider, sine rom, shared multiplier, filter and sweep state
// depends on ssvb_pkg; steered by ssvb_ctrl through t_cmd
module ssvb_datapath #(
    parameter int SAMPLE_WIDTH     = ssvb_pkg::SAMPLE_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = ssvb_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ssvb_pkg::t_cmd                     i_cmd,
    input  logic                               i_cfg_we,
    input  logic [ssvb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ssvb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample_in,
    output logic signed [SAMPLE_WIDTH-1:0]     o_sample_out,
    output logic                               o_clipped
);

    localparam int AW     = $clog2(SINE_TABLE_DEPTH);
    localparam int TAB_W  = 18;
    localparam int MA_W   = 36;
    localparam int MB_W   = 20;
    localparam int P_W    = MA_W + MB_W;
    localparam int DVD_W  = ssvb_pkg::DIV_STEPS;
    localparam int SW     = ssvb_pkg::STATE_W;
    localparam int SUM_W  = P_W + 1;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    typedef logic signed [TAB_W-1:0] t_tab [SINE_TABLE_DEPTH];

    // sin on [0, pi/2], argument in Q30, result in Q16
    function automatic longint unsigned f_quarter_sine(longint unsigned a);
        longint unsigned a2;
        longint unsigned t;
        a2 = (a * a) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd110;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd72;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd6;
        return (((a * t) >> 30) + 64'd8192) >> 14;
    endfunction

    function automatic t_tab f_build();
        t_tab            tab;
        longint unsigned u;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned r;
        longint unsigned s;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            u    = 64'(i) * 64'd4;
            quad = u / SINE_TABLE_DEPTH;
            rem  = u % SINE_TABLE_DEPTH;
            r    = quad[0] ? 64'(SINE_TABLE_DEPTH) - rem : rem;
            s    = f_quarter_sine(HALF_PI_Q30 * r / SINE_TABLE_DEPTH);
            tab[i] = (quad >= 64'd2) ? -TAB_W'(s) : TAB_W'(s);
        end
        return tab;
    endfunction

    localparam t_tab SINE_ROM = f_build();

    // config
    logic [ssvb_pkg::FS_W-1:0]          r_fs;
    logic [ssvb_pkg::FREQ_W-1:0]        r_low_lim, r_high_lim;
    logic signed [ssvb_pkg::STEP_W-1:0] r_step_cfg;
    logic [ssvb_pkg::DAMP_W-1:0]        r_damp;

    // sweep and filter state
    logic [ssvb_pkg::FREQ_W-1:0]        r_fc;
    logic signed [ssvb_pkg::STEP_W-1:0] r_step;
    logic signed [SW-1:0]               r_band, r_low;

    // per-sample work registers
    logic signed [SAMPLE_WIDTH-1:0]     r_x;
    logic [DVD_W-1:0]                   r_dvd;
    logic [ssvb_pkg::FS_W-1:0]          r_rem;
    logic [31:0]                        r_quo;
    logic signed [TAB_W-1:0]            r_t0, r_t1;
    logic [15:0]                        r_frac;
    logic signed [P_W-1:0]              r_prod;
    logic signed [MB_W-1:0]             r_coef;
    logic signed [MA_W-1:0]             r_hp;
    logic                               r_clip;
    logic signed [SAMPLE_WIDTH-1:0]     r_out;
    logic                               r_out_clip;

    logic                               cfg_hit;
    logic [ssvb_pkg::FS_W:0]            trial, trial_sub;
    logic                               trial_ge;
    logic [31:0]                        ph;
    logic [AW-1:0]                      idx, nxt;
    logic signed [MA_W-1:0]             mul_a;
    logic signed [MB_W-1:0]             mul_b;
    logic signed [TAB_W:0]              diff;
    logic signed [P_W-1:0]              rnd16, rnd14;
    logic signed [MB_W-1:0]             s_val;
    logic signed [SUM_W-1:0]            band_sum, low_sum;
    logic signed [SW-1:0]               band_sat, low_sat;
    logic                               band_clip, low_clip;
    logic signed [SAMPLE_WIDTH-1:0]     out_sat;
    logic                               out_clip;
    logic signed [ssvb_pkg::FREQ_W+2:0] fc_sum, fc_a, fc_b;
    logic signed [ssvb_pkg::STEP_W-1:0] step_a, step_b;

    localparam logic signed [ssvb_pkg::STEP_W-1:0] STEP_MIN =
        {1'b1, {(ssvb_pkg::STEP_W-1){1'b0}}};
    localparam logic signed [ssvb_pkg::STEP_W-1:0] STEP_MAX =
        {1'b0, {(ssvb_pkg::STEP_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'((64'sd1 <<< (SW-1)) - 1);
    localparam logic signed [SUM_W-1:0] S32_MIN = -S32_MAX - SUM_W'(1);
    localparam logic signed [SW-1:0] OUT_MAX = SW'((64'sd1 <<< (SAMPLE_WIDTH-1)) - 1);
    localparam logic signed [SW-1:0] OUT_MIN = -OUT_MAX - SW'(1);

    assign cfg_hit = i_cfg_we && (i_cfg_idx <= ssvb_pkg::REG_DAMPING);

    // restoring division step
    assign trial     = {r_rem, r_dvd[DVD_W-1]};
    assign trial_ge  = (trial >= {1'b0, r_fs});
    assign trial_sub = trial - {1'b0, r_fs};

    assign ph  = (r_fs == '0) ? 32'd0 : r_quo;
    assign idx = ph[31 -: AW];
    assign nxt = idx + 1'b1;

    assign diff = {r_t1[TAB_W-1], r_t1} - {r_t0[TAB_W-1], r_t0};

    always_comb begin
        case (i_cmd.mul_sel)
            ssvb_pkg::MUL_INTERP: begin
                mul_a = MA_W'(diff);
                mul_b = MB_W'({1'b0, r_frac});
            end
            ssvb_pkg::MUL_DAMP: begin
                mul_a = MA_W'(r_band);
                mul_b = MB_W'({1'b0, r_damp});
            end
            ssvb_pkg::MUL_BP: begin
                mul_a = r_hp;
                mul_b = r_coef;
            end
            ssvb_pkg::MUL_LP: begin
                mul_a = MA_W'(r_band);
                mul_b = r_coef;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // round to nearest, halves up
    assign rnd16 = (r_prod + P_W'(1 << 15)) >>> 16;
    assign rnd14 = (r_prod + P_W'(1 << 13)) >>> 14;
    assign s_val = MB_W'(r_t0) + MB_W'(rnd16);

    assign band_sum = SUM_W'(r_band) + SUM_W'(rnd16);
    assign low_sum  = SUM_W'(r_low) + SUM_W'(rnd16);

    always_comb begin
        band_clip = 1'b0;
        band_sat  = SW'(band_sum);
        if (band_sum > S32_MAX) begin
            band_clip = 1'b1;
            band_sat  = SW'(S32_MAX);
        end else if (band_sum < S32_MIN) begin
            band_clip = 1'b1;
            band_sat  = SW'(S32_MIN);
        end
        low_clip = 1'b0;
        low_sat  = SW'(low_sum);
        if (low_sum > S32_MAX) begin
            low_clip = 1'b1;
            low_sat  = SW'(S32_MAX);
        end else if (low_sum < S32_MIN) begin
            low_clip = 1'b1;
            low_sat  = SW'(S32_MIN);
        end
        out_clip = 1'b0;
        out_sat  = SAMPLE_WIDTH'(r_band);
        if (r_band > OUT_MAX) begin
            out_clip = 1'b1;
            out_sat  = SAMPLE_WIDTH'(OUT_MAX);
        end else if (r_band < OUT_MIN) begin
            out_clip = 1'b1;
            out_sat  = SAMPLE_WIDTH'(OUT_MIN);
        end
    end

    // sweep: high check first, then low check
    always_comb begin
        fc_sum = $signed({3'b000, r_fc}) + (ssvb_pkg::FREQ_W+3)'(r_step);
        fc_a   = fc_sum;
        step_a = r_step;
        if (fc_sum > $signed({3'b000, r_high_lim})) begin
            fc_a   = $signed({3'b000, r_high_lim});
            step_a = (r_step == STEP_MIN) ? STEP_MAX : -r_step;
        end
        fc_b   = fc_a;
        step_b = step_a;
        if (fc_a < $signed({3'b000, r_low_lim})) begin
            fc_b   = $signed({3'b000, r_low_lim});
            step_b = (step_a == STEP_MIN) ? STEP_MAX : -step_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs       <= ssvb_pkg::FS_RST;
            r_low_lim  <= ssvb_pkg::LOW_RST;
            r_high_lim <= ssvb_pkg::HIGH_RST;
            r_step_cfg <= ssvb_pkg::STEP_RST;
            r_damp     <= ssvb_pkg::DAMP_RST;
            r_fc       <= ssvb_pkg::LOW_RST;
            r_step     <= ssvb_pkg::STEP_RST;
            r_band     <= '0;
            r_low      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ssvb_pkg::REG_SAMPLE_RATE: r_fs       <= i_cfg_data[ssvb_pkg::FS_W-1:0];
                    ssvb_pkg::REG_SWEEP_LOW:   r_low_lim  <= i_cfg_data;
                    ssvb_pkg::REG_SWEEP_HIGH:  r_high_lim <= i_cfg_data;
                    ssvb_pkg::REG_SWEEP_STEP:
                        r_step_cfg <= i_cfg_data[ssvb_pkg::STEP_W-1:0];
                    ssvb_pkg::REG_DAMPING:     r_damp     <= i_cfg_data[ssvb_pkg::DAMP_W-1:0];
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                // reload uses the new value when that register is the one written
                r_fc <= (i_cfg_idx == ssvb_pkg::REG_SWEEP_LOW) ? i_cfg_data : r_low_lim;
                r_step <= (i_cfg_idx == ssvb_pkg::REG_SWEEP_STEP) ?
                          i_cfg_data[ssvb_pkg::STEP_W-1:0] : r_step_cfg;
                r_band <= '0;
                r_low  <= '0;
            end else begin
                if (i_cmd.ld_band) begin
                    r_band <= band_sat;
                end
                if (i_cmd.ld_low) begin
                    r_low  <= low_sat;
                    r_fc   <= ssvb_pkg::FREQ_W'(fc_b);
                    r_step <= step_b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x    <= i_sample_in;
            r_dvd  <= {r_fc, 15'd0};
            r_rem  <= '0;
            r_clip <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= trial_ge ? trial_sub[ssvb_pkg::FS_W-1:0] : trial[ssvb_pkg::FS_W-1:0];
            r_quo <= {r_quo[30:0], trial_ge};
        end
        if (i_cmd.rom_rd) begin
            r_t0   <= SINE_ROM[idx];
            r_t1   <= SINE_ROM[nxt];
            r_frac <= ph[31-AW -: 16];
        end
        r_prod <= P_W'(mul_a * mul_b);
        if (i_cmd.ld_coef) begin
            r_coef <= s_val <<< 1;
        end
        if (i_cmd.ld_hp) begin
            r_hp <= MA_W'(r_x) - MA_W'(r_low) - MA_W'(rnd14);
        end
        if (i_cmd.ld_band && band_clip) begin
            r_clip <= 1'b1;
        end
        if (i_cmd.ld_low && low_clip) begin
            r_clip <= 1'b1;
        end
        if (i_cmd.ld_out) begin
            r_out      <= out_sat;
            r_out_clip <= r_clip | out_clip;
        end
    end

    assign o_sample_out = r_out;
    assign o_clipped    = r_out_clip;

endmodule

// ===== hdl/swept_state_variable_bandpass.sv =====
// auto-wah: swept chamberlin state-variable filter, band-pass output
// top level; instantiates ssvb_ctrl and ssvb_datapath, depends on ssvb_pkg
//
// input channel: i_in_valid / o_in_stall carry one sample beat (i_sample_in).
// output channel: o_out_valid / i_out_stall carry one result beat
// (o_sample_out, o_clipped) for each input beat, in order.
// config: i_cfg_we writes i_cfg_data to register i_cfg_idx;
// write only while no sample is in flight. any valid index reloads the
// sweep from the low limit and the initial step and clears the filter.
// sequence: a sample goes from accept to result valid through phase division
// at one bit per cycle, one sine rom read, seven steps through one shared
// multiplier and one output load. one sample is worked on at a time and
// the idle state takes the next one in the cycle after the output load;
// the output load is held back only while an earlier stalled result still
// holds the output register.
// a finished result sits in an output register, so the next sample is
// accepted while it waits; the last step waits for that register to drain.
// reset (synchronous, active low) restores register defaults, the sweep
// start and zero filter state; nothing is in flight afterwards.
module swept_state_variable_bandpass #(
    parameter int SAMPLE_WIDTH     = ssvb_pkg::SAMPLE_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = ssvb_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]    o_sample_out,
    output logic                              o_clipped,
    input  logic                              i_cfg_we,
    input  logic [ssvb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ssvb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    ssvb_pkg::t_cmd cmd;

    ssvb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    ssvb_datapath #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

endmodule

// ===== hdl/ssvb_checker.sv =====
// port-level checks for swept_state_variable_bandpass
// bound to the top level below; depends on nothing else
module ssvb_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [SAMPLE_WIDTH-1:0] o_sample_out
);

    // a stalled result beat stays and holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled output beat changed");

    // the block is busy right after it takes a sample
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // a result never shows up in the cycle after an accept
    a_no_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result too early");

    // a new result comes only at the end of sample work
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result rose while idle");

endmodule

bind swept_state_variable_bandpass ssvb_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ssvb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_sample_out (o_sample_out)
);

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for swept_state_variable_bandpass (auto-wah band-pass)
// depends on ssvb_pkg and the block's rtl; a scoreboard class predicts every result beat
module tb_top;

    localparam int SW         = ssvb_pkg::SAMPLE_WIDTH_DEF;
    localparam int TAB_N      = ssvb_pkg::SINE_TABLE_DEPTH_DEF;
    localparam int FS_W       = ssvb_pkg::FS_W;
    localparam int FREQ_W     = ssvb_pkg::FREQ_W;
    localparam int STEP_W     = ssvb_pkg::STEP_W;
    localparam int DAMP_W     = ssvb_pkg::DAMP_W;
    localparam int CFG_IDX_W  = ssvb_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ssvb_pkg::CFG_DATA_W;
    localparam int MAX_CYC    = 1000000;
    localparam int N_PHASES   = 8;
    localparam int PHASE_LEN  = 250;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;

    class bandpass_scoreboard;
        int              tab[TAB_N];
        logic [FS_W-1:0]   fs;
        logic [FREQ_W-1:0] lo_lim, hi_lim;
        logic [STEP_W-1:0] step0;
        logic [DAMP_W-1:0] damp;
        int              band, low;
        longint          fc;
        int              cur_step;
        bit              sat_hit;
        logic [SW:0]     pending[$];
        int              n_err, n_checked, n_clip;

        function new();
            longint unsigned u, r, a;
            for (int i = 0; i < TAB_N; i++) begin
                u = longint'(i) * 4;
                r = ((u / TAB_N) & 1) ? TAB_N - (u % TAB_N) : u % TAB_N;
                a = 64'd1686629713 * r / TAB_N;
                tab[i] = ((u / TAB_N) >= 2) ? -quarter_sine(a) : quarter_sine(a);
            end
            fs = ssvb_pkg::FS_RST; lo_lim = ssvb_pkg::LOW_RST; hi_lim = ssvb_pkg::HIGH_RST;
            step0 = ssvb_pkg::STEP_RST;
            damp = ssvb_pkg::DAMP_RST;
            restart_sweep();
        endfunction

        function int quarter_sine(longint unsigned a);
            longint unsigned a2, t;
            int divs[5];
            divs = '{110, 72, 42, 20, 6};
            a2 = (a * a) >> 30;
            t = 64'd1 << 30;
            for (int k = 0; k < 5; k++)
                t = (64'd1 << 30) - ((a2 * t) >> 30) / divs[k];
            return int'((((a * t) >> 30) + 8192) >> 14);
        endfunction

        function void restart_sweep();
            fc = lo_lim; cur_step = int'($signed(step0)); band = 0; low = 0;
        endfunction

        function longint rnd(longint v, int n);
            return (v + (64'sd1 <<< (n - 1))) >>> n;
        endfunction

        function longint clamp(longint v, int bits);
            longint hi, lo;
            hi = (64'sd1 <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin sat_hit = 1; return hi; end
            if (v < lo) begin sat_hit = 1; return lo; end
            return v;
        endfunction

        function int flip(int s);
            return (s <= -(1 << 24)) ? (1 << 24) - 1 : -s;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                ssvb_pkg::REG_SAMPLE_RATE: fs = d[FS_W-1:0];
                ssvb_pkg::REG_SWEEP_LOW:   lo_lim = d[FREQ_W-1:0];
                ssvb_pkg::REG_SWEEP_HIGH:  hi_lim = d[FREQ_W-1:0];
                ssvb_pkg::REG_SWEEP_STEP:  step0 = d[STEP_W-1:0];
                ssvb_pkg::REG_DAMPING:     damp = d[DAMP_W-1:0];
                default: return;
            endcase
            restart_sweep();
        endfunction

        // one input beat: filter it and move the sweep
        function void note_sample(logic signed [SW-1:0] x);
            longint unsigned ph, v;
            int idx, nxt;
            longint frac, s, coef, hp, bp, lp, y;
            sat_hit = 0;
            ph = (fs != 0) ? (((longint'(fc) << 15) / fs) & 64'hFFFF_FFFF) : 0;
            v = ph * TAB_N;
            idx = int'(v >> 32);
            nxt = (idx + 1 >= TAB_N) ? 0 : idx + 1;
            frac = longint'((v >> 16) & 16'hFFFF);
            s = tab[idx] + rnd((longint'(tab[nxt]) - tab[idx]) * frac, 16);
            coef = 2 * s;
            hp = longint'(x) - low - rnd(longint'(damp) * band, 14);
            bp = clamp(band + rnd(coef * hp, 16), 32);
            lp = clamp(low + rnd(coef * bp, 16), 32);
            band = int'(bp); low = int'(lp);
            y = clamp(bp, SW);
            pending.push_back({sat_hit, y[SW-1:0]});
            // signed compares, the sum can go below zero
            fc = fc + cur_step;
            if (fc > longint'(hi_lim)) begin fc = hi_lim; cur_step = flip(cur_step); end
            if (fc < longint'(lo_lim)) begin fc = lo_lim; cur_step = flip(cur_step); end
        endfunction

        task report(string what);
            n_err++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(logic signed [SW-1:0] y, logic clip);
            logic [SW:0] e;
            if (pending.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (clip) n_clip++;
            if (y !== e[SW-1:0])
                report($sformatf("sample_out %0d, expected %0d", y, $signed(e[SW-1:0])));
            if (clip !== e[SW])
                report($sformatf("clipped %0b, expected %0b", clip, e[SW]));
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_in_valid = 0, i_out_stall = 1, i_cfg_we = 0;
    logic signed [SW-1:0] i_sample_in = '0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = ssvb_pkg::REG_SAMPLE_RATE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_in_stall, o_out_valid, o_clipped;
    logic signed [SW-1:0] o_sample_out;

    bandpass_scoreboard sb = new();
    int cyc = 0;
    bit no_gaps = 0;
    int n_cfg = 0;

    swept_state_variable_bandpass dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= MAX_CYC) begin
            $display("timeout after %0d cycles", cyc);
            $display("tb_top NOT OK");
            $finish;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_sample(i_sample_in);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_sample_out, o_clipped);
    end

    // receiver stalls a random number of cycles per beat, none while no_gaps is set
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = no_gaps ? 0 : $urandom_range(0, 11);
            repeat (n) begin @(negedge i_clk); i_out_stall = 1; end
            @(negedge i_clk);
            i_out_stall = 0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    task send_sample(logic signed [SW-1:0] x);
        int n;
        n = no_gaps ? 0 : $urandom_range(0, 11);
        repeat (n) begin @(negedge i_clk); i_in_valid = 0; end
        @(negedge i_clk);
        i_in_valid = 1;
        i_sample_in = x;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task drain();
        @(negedge i_clk);
        i_in_valid = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        @(negedge i_clk);
        i_cfg_we = 1; i_cfg_idx = idx; i_cfg_data = CFG_DATA_W'(d);
        sb.write_reg(idx, CFG_DATA_W'(d));
        n_cfg++;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return $signed(SW'($urandom_range(0, 4095))) - 2048;
            1: return $signed(SW'($urandom_range(0, 262143))) - 131072;
            default: return SW'($urandom);
        endcase
    endfunction

    task set_phase(int p);
        case (p)
            0: begin
                // low rate, full range, most negative step
                write_cfg(ssvb_pkg::REG_SAMPLE_RATE, 8000);
                write_cfg(ssvb_pkg::REG_SWEEP_LOW, 0);
                write_cfg(ssvb_pkg::REG_SWEEP_HIGH, 32'h7FFF_FFFF);
                write_cfg(ssvb_pkg::REG_SWEEP_STEP, 32'(-(1 << 24)));
                write_cfg(ssvb_pkg::REG_DAMPING, 0);
            end
            1: begin
                write_cfg(ssvb_pkg::REG_SAMPLE_RATE, 192000);
                write_cfg(ssvb_pkg::REG_DAMPING, 32'hFFFF);
                write_cfg(ssvb_pkg::REG_SWEEP_STEP, (1 << 24) - 1);
            end
            2: write_cfg(ssvb_pkg::REG_SAMPLE_RATE, 0);
            3: begin
                // high limit under low limit
                write_cfg(ssvb_pkg::REG_SAMPLE_RATE, 44100);
                write_cfg(ssvb_pkg::REG_SWEEP_LOW, 32'd300000000);
                write_cfg(ssvb_pkg::REG_SWEEP_HIGH, 32'd100000000);
                write_cfg(ssvb_pkg::REG_SWEEP_STEP, 32'd50000);
            end
            4: begin
                // center frequency beyond fs, phase wraps
                write_cfg(ssvb_pkg::REG_SAMPLE_RATE, 8000);
                write_cfg(ssvb_pkg::REG_SWEEP_LOW, 32'd600000000);
                write_cfg(ssvb_pkg::REG_SWEEP_HIGH, 32'd2000000000);
                write_cfg(ssvb_pkg::REG_SWEEP_STEP, 32'd9000000);
                write_cfg(ssvb_pkg::REG_DAMPING, 32'd2000);
                write_cfg(REG_UNMAPPED, $urandom);
            end
            default: begin
                write_cfg(ssvb_pkg::REG_SAMPLE_RATE, ($urandom_range(0, 7) == 0) ?
                          $urandom_range(0, (1 << FS_W) - 1) : $urandom_range(8000, 192000));
                write_cfg(ssvb_pkg::REG_SWEEP_LOW, $urandom_range(0, 200000000));
                write_cfg(ssvb_pkg::REG_SWEEP_HIGH, ($urandom_range(0, 3) == 0) ?
                          $urandom : $urandom_range(200000000, 800000000));
                write_cfg(ssvb_pkg::REG_SWEEP_STEP, $urandom);
                write_cfg(ssvb_pkg::REG_DAMPING, $urandom_range(0, 65535));
            end
        endcase
    endtask

    initial begin
        logic signed [SW-1:0] edge_vals[8];
        edge_vals = '{24'sh7FFFFF, -24'sh800000, 24'sd0, -24'sd1, 24'sd1, 24'sh555555,
                      24'shAAAAAA, 24'sh7FFFFF};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        // defaults from reset: extremes, then full-scale values of alternating sign
        foreach (edge_vals[i]) send_sample(edge_vals[i]);
        for (int i = 0; i < 10; i++) send_sample(i[0] ? -24'sh800000 : 24'sh7FFFFF);
        drain();
        for (int p = 0; p < N_PHASES; p++) begin
            set_phase(p);
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
                send_sample(rand_sample());
            end
            no_gaps = 0;
            drain();
        end
        repeat (60) @(posedge i_clk);
        $display("checked %0d result beats (%0d clipped) over %0d register writes",
                 sb.n_checked, sb.n_clip, n_cfg);
        $display("sweeps covered zero rate, wrapped phase, crossed limits and full-range steps");
        if (sb.n_err == 0 && sb.pending.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
